// File: hw/rtl/bnndm_pkg.sv
// shared constants and types for the bayer nearest neighbor demosaic unit
package bnndm_pkg;

   // line store geometry and sample size
   localparam int MAX_WIDTH   = 4096;
   localparam int SAMPLE_BITS = 12;
   localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
   // enough bits to hold MAX_WIDTH itself
   localparam int EFF_BITS    = ADDR_BITS + 1;

   // register file
   localparam int WIDTH_BITS     = 13;
   localparam int HEIGHT_BITS    = 16;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 13'd640;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;
   localparam int MIN_SIZE = 3;

   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_index_type;

endpackage

// File: hw/rtl/bnndm_req_if.sv
// raw sample stream channel
interface bnndm_req_if;
   logic                             valid;
   logic                             ready;
   logic [bnndm_pkg::SAMPLE_BITS-1:0] raw_sample;

   modport source (output valid, output raw_sample, input ready);
   modport sink   (input valid, input raw_sample, output ready);
endinterface

// File: hw/rtl/bnndm_rsp_if.sv
// rgb pixel stream channel
interface bnndm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bnndm_pkg::SAMPLE_BITS-1:0] red;
   logic [bnndm_pkg::SAMPLE_BITS-1:0] green;
   logic [bnndm_pkg::SAMPLE_BITS-1:0] blue;
   logic                             row_end;
   logic                             frame_end;

   modport source (output valid, output red, output green, output blue,
                   output row_end, output frame_end, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input row_end, input frame_end, output ready);
endinterface

// File: hw/rtl/bnndm_ram.sv
// simple dual port ram with registered read data
module bnndm_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 12
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/bayer_nearest_neighbor_demosaic_unit.sv
// top level of the bayer nearest neighbor demosaic unit
//
// req_chan carries raw bayer samples in raster order, one per transaction.
// rsp_chan carries the interior pixels of the frame as rgb triples, with
// row_end on the last pixel of each output row and frame_end on the last
// pixel of the frame. border positions produce no output transaction.
// the output pixel at (x-1, y-1) is produced by the sample at (x, y).
// frame_width and frame_height are set over the csr_ apb port (byte
// addresses 0 and 4) while the block is idle.
// throughput: one sample per clock unless the output stalls. a sample reads
// both line stores at the edge that accepts it and enters the read stage;
// as it leaves, the window shifts, both stores are written back and the pixel
// is loaded into the output register behind rsp_chan.valid. consecutive
// samples always hit different columns, so the memory ports never collide.
// when the receiver stalls, the output register holds its pixel; border
// samples still pass, the next interior sample waits in the read stage and
// req_chan.ready drops until the output frees up.
// reset holds req_chan.ready low, clears the raster counters, the window and
// the pipeline and loads the default 640 x 480 size; line store contents are
// undefined until the first rows of a frame have written them.
module bayer_nearest_neighbor_demosaic_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   bnndm_req_if.sink                             req_chan,
   bnndm_rsp_if.source                           rsp_chan,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [bnndm_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [bnndm_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [bnndm_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   localparam int SB = bnndm_pkg::SAMPLE_BITS;
   localparam int AB = bnndm_pkg::ADDR_BITS;
   localparam int EB = bnndm_pkg::EFF_BITS;
   localparam int WB = bnndm_pkg::WIDTH_BITS;
   localparam int HB = bnndm_pkg::HEIGHT_BITS;

   // configuration registers
   logic [WB-1:0] width_ff, width_in;
   logic [HB-1:0] height_ff, height_in;
   logic          csr_write;
   bnndm_pkg::csr_index_type csr_index;

   // raster counters
   logic [AB-1:0] col_ff, col_in;
   logic [HB-1:0] row_ff, row_in;

   // read stage: sample whose line store read is in flight
   logic          p_vld_ff, p_vld_in;
   logic [SB-1:0] p_sample_ff;
   logic [AB-1:0] p_col_ff;
   logic          p_res_ff, p_cx_odd_ff, p_cy_odd_ff, p_row_end_ff, p_frame_end_ff;

   // window: entries 0..2 from two rows up, 3..5 from the row above
   logic [SB-1:0] win_ff [6];

   // output register
   logic          o_vld_ff, o_vld_in;
   logic [SB-1:0] o_red_ff, o_green_ff, o_blue_ff;
   logic          o_row_end_ff, o_frame_end_ff;

   logic          accept, p_go, p_stall;
   logic [SB-1:0] rd_a, rd_b;
   logic [EB-1:0] w_eff, w_last, x_ext;
   logic [HB-1:0] h_eff, h_last;
   logic          pos_res, pos_row_end, pos_frame_end;
   logic [SB-1:0] red_sel, green_sel, blue_sel;

   // apb register access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = bnndm_pkg::csr_index_type'(csr_paddr[2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            bnndm_pkg::REG_FRAME_WIDTH:  width_in  = csr_pwdata[WB-1:0];
            bnndm_pkg::REG_FRAME_HEIGHT: height_in = csr_pwdata[HB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         bnndm_pkg::REG_FRAME_WIDTH:
            csr_prdata = bnndm_pkg::CSR_DATA_BITS'(width_ff);
         bnndm_pkg::REG_FRAME_HEIGHT:
            csr_prdata = bnndm_pkg::CSR_DATA_BITS'(height_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // clamped frame size
   always_comb begin
      if (32'(width_ff) > 32'(bnndm_pkg::MAX_WIDTH)) begin
         w_eff = EB'(bnndm_pkg::MAX_WIDTH);
      end else if (32'(width_ff) < 32'(bnndm_pkg::MIN_SIZE)) begin
         w_eff = EB'(bnndm_pkg::MIN_SIZE);
      end else begin
         w_eff = EB'(32'(width_ff));
      end
      if (32'(height_ff) < 32'(bnndm_pkg::MIN_SIZE)) begin
         h_eff = HB'(bnndm_pkg::MIN_SIZE);
      end else begin
         h_eff = height_ff;
      end
      w_last = w_eff - EB'(1);
      h_last = h_eff - HB'(1);
      x_ext  = EB'(col_ff);
   end

   // handshake and pipeline control
   assign p_stall        = p_vld_ff && p_res_ff && o_vld_ff && !rsp_chan.ready;
   assign p_go           = p_vld_ff && !p_stall;
   assign req_chan.ready = !reset && (!p_vld_ff || p_go);
   assign accept         = req_chan.valid && req_chan.ready;

   // position classification of the incoming sample
   always_comb begin
      pos_res       = (col_ff >= AB'(2)) && (row_ff >= HB'(2)) &&
                      (x_ext <= w_last) && (row_ff <= h_last);
      pos_row_end   = (x_ext == w_last);
      pos_frame_end = pos_row_end && (row_ff == h_last);
   end

   // raster counter advance
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (x_ext >= w_last) begin
            col_in = '0;
            row_in = (row_ff >= h_last) ? '0 : row_ff + HB'(1);
         end else begin
            col_in = col_ff + AB'(1);
         end
      end
   end

   always_comb begin
      p_vld_in = p_vld_ff;
      if (accept) begin
         p_vld_in = 1'b1;
      end else if (p_go) begin
         p_vld_in = 1'b0;
      end
   end

   // line stores: row above and row two above
   bnndm_ram #(.DEPTH(bnndm_pkg::MAX_WIDTH), .WIDTH(SB)) line_a (
      .clock (clock),
      .we    (p_go),
      .waddr (p_col_ff),
      .wdata (p_sample_ff),
      .re    (accept),
      .raddr (col_ff),
      .rdata (rd_a)
   );

   bnndm_ram #(.DEPTH(bnndm_pkg::MAX_WIDTH), .WIDTH(SB)) line_b (
      .clock (clock),
      .we    (p_go),
      .waddr (p_col_ff),
      .wdata (rd_a),
      .re    (accept),
      .raddr (col_ff),
      .rdata (rd_b)
   );

   // neighbor selection on the shifted window
   always_comb begin
      unique case ({p_cy_odd_ff, p_cx_odd_ff})
         2'b11: begin
            red_sel   = win_ff[5];
            green_sel = win_ff[4];
            blue_sel  = win_ff[1];
         end
         2'b10: begin
            red_sel   = rd_a;
            green_sel = win_ff[5];
            blue_sel  = win_ff[2];
         end
         2'b01: begin
            red_sel   = win_ff[2];
            green_sel = win_ff[5];
            blue_sel  = win_ff[4];
         end
         default: begin
            red_sel   = p_sample_ff;
            green_sel = rd_a;
            blue_sel  = win_ff[5];
         end
      endcase
   end

   always_comb begin
      o_vld_in = o_vld_ff;
      if (p_go && p_res_ff) begin
         o_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         o_vld_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bnndm_pkg::WIDTH_RESET;
         height_ff <= bnndm_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         p_vld_ff  <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         p_vld_ff  <= p_vld_in;
         o_vld_ff  <= o_vld_in;
      end
   end

   // window shift once per processed sample
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (p_go) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= rd_b;
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= rd_a;
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         p_sample_ff    <= req_chan.raw_sample;
         p_col_ff       <= col_ff;
         p_res_ff       <= pos_res;
         p_cx_odd_ff    <= ~col_ff[0];
         p_cy_odd_ff    <= ~row_ff[0];
         p_row_end_ff   <= pos_row_end;
         p_frame_end_ff <= pos_frame_end;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (p_go && p_res_ff) begin
         o_red_ff       <= red_sel;
         o_green_ff     <= green_sel;
         o_blue_ff      <= blue_sel;
         o_row_end_ff   <= p_row_end_ff;
         o_frame_end_ff <= p_frame_end_ff;
      end
   end

   assign rsp_chan.valid     = o_vld_ff;
   assign rsp_chan.red       = o_red_ff;
   assign rsp_chan.green     = o_green_ff;
   assign rsp_chan.blue      = o_blue_ff;
   assign rsp_chan.row_end   = o_row_end_ff;
   assign rsp_chan.frame_end = o_frame_end_ff;

   // a line store write never lands on the column being read
   assert property (@(posedge clock) disable iff (reset)
      (p_go && accept) |-> (p_col_ff != col_ff))
      else $error("line store read and write hit the same column");

   // a stalled sample keeps its column and its read data
   assert property (@(posedge clock) disable iff (reset)
      p_stall |=> (p_vld_ff && $stable(p_col_ff) && $stable(rd_a) && $stable(rd_b)))
      else $error("stalled sample lost its line store data");

   // a processed interior sample always reaches the output register
   assert property (@(posedge clock) disable iff (reset)
      (p_go && p_res_ff) |=> o_vld_ff)
      else $error("interior pixel dropped");

   // reset returns the raster position to the frame origin
   assert property (@(posedge clock)
      $past(reset) |-> (col_ff == '0 && row_ff == '0 && !p_vld_ff && !o_vld_ff))
      else $error("raster state not cleared by reset");

endmodule
